// ----- design/psms_pkg.sv -----
// types, constants and small decode functions shared by the move sequencer
// no dependencies
`default_nettype none

package psms_pkg;

    localparam int unsigned CODE_W = 5;
    localparam int unsigned FACE_W = 3;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned LINE_W = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned SETTLE_W = 16;
    localparam int unsigned TIME_W = 24;
    localparam int unsigned QUARTER_W = 12;
    localparam int unsigned PULSE_W = 13;

    localparam logic [CODE_W-1:0] CODE_MAX = 5'd17;

    // turn kinds
    localparam logic [KIND_W-1:0] KIND_CW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HALF = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DWELL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUARTER = 2'd3;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd500;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd50;
    localparam logic [TIME_W-1:0] DWELL_RESET = 24'd100000;
    localparam logic [QUARTER_W-1:0] QUARTER_RESET = 12'd200;

    typedef struct packed {
        logic                is_tick;
        logic                code_ok;
        logic                last;
        logic [FACE_W-1:0]   face;
        logic [KIND_W-1:0]   kind;
    } t_item;

    typedef struct packed {
        logic                pair;
        logic [KIND_W-1:0]   kind_b;
        logic [FACE_W-1:0]   face_b;
        logic [KIND_W-1:0]   kind_a;
        logic [FACE_W-1:0]   face_a;
    } t_cmd;

    typedef struct packed {
        logic [LINE_W-1:0]   step_lines;
        logic [LINE_W-1:0]   dir_lines;
        logic                busy_res;
        logic                accepted;
    } t_result;

    function automatic logic [FACE_W-1:0] code_face(input logic [CODE_W-1:0] code);
        logic [FACE_W-1:0] face;
        case (code) inside
            [5'd0:5'd2]:   face = 3'd0;
            [5'd3:5'd5]:   face = 3'd1;
            [5'd6:5'd8]:   face = 3'd2;
            [5'd9:5'd11]:  face = 3'd3;
            [5'd12:5'd14]: face = 3'd4;
            [5'd15:5'd17]: face = 3'd5;
            default:       face = 3'd0;
        endcase
        return face;
    endfunction

    function automatic logic [KIND_W-1:0] code_kind(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] base;
        base = CODE_W'({2'b00, code_face(code)} * 5'd3);
        return KIND_W'(code - base);
    endfunction

    function automatic logic [FACE_W-1:0] opposite_face(input logic [FACE_W-1:0] face);
        logic [FACE_W-1:0] opp;
        case (face)
            3'd0:    opp = 3'd5;
            3'd1:    opp = 3'd3;
            3'd2:    opp = 3'd4;
            3'd3:    opp = 3'd1;
            3'd4:    opp = 3'd2;
            3'd5:    opp = 3'd0;
            default: opp = 3'd0;
        endcase
        return opp;
    endfunction

    function automatic logic [LINE_W-1:0] face_bit(input logic [FACE_W-1:0] face);
        logic [LINE_W-1:0] bits;
        bits = '0;
        if (face < FACE_W'(LINE_W)) begin
            bits[face] = 1'b1;
        end
        return bits;
    endfunction

    function automatic t_cmd make_single(input logic [FACE_W-1:0] face,
                                         input logic [KIND_W-1:0] kind);
        t_cmd cmd;
        cmd = '0;
        cmd.face_a = face;
        cmd.kind_a = kind;
        return cmd;
    endfunction

endpackage

`default_nettype wire

// ----- design/paired_stepper_move_sequencer.sv -----
// path: an item is registered in the item queue, and its result in the result queue
// throughput: one item per cycle while the result queue has room; a move that
// flushes a held, non-opposite code stores it, then itself (one store write port)
// reset: synchronous active low; clears queues, pairing and run state and
// restores register defaults; command store contents are not cleared
`default_nettype none

module paired_stepper_move_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              i_mode,
    input  wire logic [psms_pkg::CODE_W-1:0]       i_move_code,
    input  wire logic                              i_last_move,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [psms_pkg::LINE_W-1:0]            o_step_lines,
    output logic [psms_pkg::LINE_W-1:0]            o_dir_lines,
    output logic                                   o_busy_res,
    output logic                                   o_accepted,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psms_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [psms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned RESULT_W = $bits(psms_pkg::t_result);

    psms_pkg::t_item   item;
    logic              item_valid, item_take;
    psms_pkg::t_result result_in, result_out;
    logic              result_push, result_full;

    assign o_cfg_ready = 1'b1;

    psms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_move_code  (i_move_code),
        .i_last_move  (i_last_move),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_take  (item_take)
    );

    psms_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_item_take   (item_take),
        .o_result      (result_in),
        .o_result_push (result_push),
        .i_result_full (result_full)
    );

    psms_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (2)
    ) u_result_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (result_push),
        .i_wr_data (result_in),
        .o_full    (result_full),
        .i_rd_en   (pop),
        .o_rd_data (result_out),
        .o_empty   (empty)
    );

    assign o_step_lines = result_out.step_lines;
    assign o_dir_lines  = result_out.dir_lines;
    assign o_busy_res   = result_out.busy_res;
    assign o_accepted   = result_out.accepted;

endmodule

`default_nettype wire

// ----- design/psms_fifo.sv -----
// small first-in first-out queue of packed words, flop based
// no dependencies
`default_nettype none

module psms_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output logic [WIDTH-1:0]      o_rd_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_go, rd_go;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/psms_front.sv -----
// front end: takes input beats, splits move codes into face and turn kind,
// and queues the classified items for the back end; uses psms_pkg, psms_fifo
`default_nettype none

module psms_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         i_mode,
    input  wire logic [psms_pkg::CODE_W-1:0]  i_move_code,
    input  wire logic                         i_last_move,
    output psms_pkg::t_item                   o_item,
    output logic                              o_item_valid,
    input  wire logic                         i_item_take
);

    localparam int unsigned ITEM_W = $bits(psms_pkg::t_item);

    psms_pkg::t_item item;
    logic            item_empty;

    always_comb begin
        item.is_tick = i_mode;
        item.code_ok = (i_move_code <= psms_pkg::CODE_MAX);
        item.last    = i_last_move;
        item.face    = psms_pkg::code_face(i_move_code);
        item.kind    = psms_pkg::code_kind(i_move_code);
    end

    psms_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_item_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_data (item),
        .o_full    (full),
        .i_rd_en   (i_item_take),
        .o_rd_data (o_item),
        .o_empty   (item_empty)
    );

    assign o_item_valid = !item_empty;

endmodule

`default_nettype wire

// ----- design/psms_back.sv -----
// back end: pairs opposite-face moves, keeps the command store and runs the
// direction, settle, pulse and dwell sequence on tick items; uses psms_pkg
`default_nettype none

module psms_back #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [psms_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [psms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire psms_pkg::t_item                   i_item,
    input  wire logic                              i_item_valid,
    output logic                                   o_item_take,
    output psms_pkg::t_result                      o_result,
    output logic                                   o_result_push,
    input  wire logic                              i_result_full
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);
    localparam int unsigned TIME_W = psms_pkg::TIME_W;
    localparam int unsigned PULSE_W = psms_pkg::PULSE_W;
    localparam int unsigned LINE_W = psms_pkg::LINE_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE_A,
        PH_SETTLE_B,
        PH_JOINT,
        PH_EXTRA,
        PH_DWELL
    } t_phase;

    // configuration
    logic [psms_pkg::HALF_W-1:0]    r_half_period;
    logic [psms_pkg::SETTLE_W-1:0]  r_settle;
    logic [TIME_W-1:0]              r_dwell;
    logic [psms_pkg::QUARTER_W-1:0] r_quarter;

    // pairing state
    logic                        r_held_valid, n_held_valid;
    logic [psms_pkg::FACE_W-1:0] r_held_face, n_held_face;
    logic [psms_pkg::KIND_W-1:0] r_held_kind, n_held_kind;
    logic                        r_split, n_split;

    // command store
    psms_pkg::t_cmd   r_store [QUEUE_DEPTH];
    psms_pkg::t_cmd   r_head;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    psms_pkg::t_cmd   wr_cmd;

    // runner
    t_phase              r_phase, n_phase;
    logic [PULSE_W-1:0]  r_pulse, n_pulse;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [LINE_W-1:0]   r_step, n_step;
    logic [LINE_W-1:0]   r_dir, n_dir;

    logic                        go, accepted, no_room, opp_match;
    logic [psms_pkg::QUARTER_W-1:0] quarter;
    logic [PULSE_W-1:0]          steps_a, steps_b, joint_n;
    logic [LINE_W-1:0]           joint_mask, longer_mask, pulse_mask;
    logic                        extra_needed, pulse_done;
    logic [TIME_W-1:0]           half_ext, settle_ext;
    logic [PULSE_W-1:0]          pulse_dec;

    assign go         = i_item_valid && !i_result_full;
    assign no_room    = (r_count > ROOM_LIMIT);
    assign opp_match  = (psms_pkg::opposite_face(r_held_face) == i_item.face);
    assign half_ext   = TIME_W'(r_half_period);
    assign settle_ext = TIME_W'(r_settle);

    // per-command step figures, from the head command
    always_comb begin
        quarter = (r_quarter == '0) ? psms_pkg::QUARTER_W'(1) : r_quarter;
        steps_a = (r_head.kind_a == psms_pkg::KIND_HALF) ? {quarter, 1'b0} : {1'b0, quarter};
        steps_b = (r_head.kind_b == psms_pkg::KIND_HALF) ? {quarter, 1'b0} : {1'b0, quarter};
        joint_n = (r_head.pair && (steps_b < steps_a)) ? steps_b : steps_a;
        joint_mask = psms_pkg::face_bit(r_head.face_a)
                   | (r_head.pair ? psms_pkg::face_bit(r_head.face_b) : '0);
        longer_mask = (steps_a > steps_b) ? psms_pkg::face_bit(r_head.face_a)
                                          : psms_pkg::face_bit(r_head.face_b);
        extra_needed = r_head.pair && (steps_a != steps_b);
        pulse_mask = (r_phase == PH_EXTRA) ? longer_mask : joint_mask;
        pulse_dec = (r_pulse != '0) ? r_pulse - 1'b1 : '0;
    end

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_face  = r_held_face;
        n_held_kind  = r_held_kind;
        n_split      = r_split;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_count      = r_count;
        n_phase      = r_phase;
        n_pulse      = r_pulse;
        n_time       = r_time;
        n_step       = r_step;
        n_dir        = r_dir;
        wr_en        = 1'b0;
        wr_cmd       = '0;
        accepted     = 1'b0;
        pulse_done   = 1'b0;
        o_item_take   = 1'b0;
        o_result_push = 1'b0;

        if (go) begin
            o_item_take   = 1'b1;
            o_result_push = 1'b1;
            if (i_item.is_tick) begin
                case (r_phase)
                    PH_IDLE: begin
                        if (r_count != '0) begin
                            n_dir = (r_head.kind_a == psms_pkg::KIND_CW)
                                  ? (r_dir | psms_pkg::face_bit(r_head.face_a))
                                  : (r_dir & ~psms_pkg::face_bit(r_head.face_a));
                            n_time  = settle_ext;
                            n_phase = PH_SETTLE_A;
                        end
                    end
                    PH_SETTLE_A, PH_SETTLE_B: begin
                        if (r_time > TIME_W'(1)) begin
                            n_time = r_time - 1'b1;
                        end else if (r_phase == PH_SETTLE_A && r_head.pair) begin
                            n_dir = (r_head.kind_b == psms_pkg::KIND_CW)
                                  ? (r_dir | psms_pkg::face_bit(r_head.face_b))
                                  : (r_dir & ~psms_pkg::face_bit(r_head.face_b));
                            n_time  = settle_ext;
                            n_phase = PH_SETTLE_B;
                        end else begin
                            n_phase = PH_JOINT;
                            n_step  = joint_mask;
                            n_pulse = joint_n;
                            n_time  = half_ext;
                        end
                    end
                    PH_JOINT, PH_EXTRA: begin
                        // one tick of the pulse train: high half, low half, count
                        if (r_time > TIME_W'(1)) begin
                            n_time = r_time - 1'b1;
                        end else begin
                            n_time = half_ext;
                            if (r_step != '0) begin
                                n_step = '0;
                            end else begin
                                n_pulse = pulse_dec;
                                if (pulse_dec != '0) begin
                                    n_step = pulse_mask;
                                end else begin
                                    pulse_done = 1'b1;
                                end
                            end
                        end
                        if (pulse_done) begin
                            if (r_phase == PH_JOINT && extra_needed) begin
                                n_phase = PH_EXTRA;
                                n_step  = longer_mask;
                                n_pulse = {1'b0, quarter};
                                n_time  = half_ext;
                            end else begin
                                n_phase = PH_DWELL;
                                n_time  = r_dwell;
                            end
                        end
                    end
                    PH_DWELL: begin
                        if (r_time > TIME_W'(1)) begin
                            n_time = r_time - 1'b1;
                        end else begin
                            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else if (r_split) begin
                // second beat of a move that flushes a held code and itself
                wr_en    = 1'b1;
                wr_cmd   = psms_pkg::make_single(i_item.face, i_item.kind);
                n_split  = 1'b0;
                accepted = 1'b1;
            end else if (i_item.code_ok && !no_room) begin
                accepted = 1'b1;
                if (r_held_valid && opp_match) begin
                    wr_en         = 1'b1;
                    wr_cmd        = psms_pkg::make_single(r_held_face, r_held_kind);
                    wr_cmd.pair   = 1'b1;
                    wr_cmd.face_b = i_item.face;
                    wr_cmd.kind_b = i_item.kind;
                    n_held_valid  = 1'b0;
                end else if (r_held_valid && i_item.last) begin
                    // one store write per cycle: the move itself stays queued and is written via r_split
                    wr_en         = 1'b1;
                    wr_cmd        = psms_pkg::make_single(r_held_face, r_held_kind);
                    n_held_valid  = 1'b0;
                    n_split       = 1'b1;
                    o_item_take   = 1'b0;
                    o_result_push = 1'b0;
                end else if (r_held_valid) begin
                    wr_en       = 1'b1;
                    wr_cmd      = psms_pkg::make_single(r_held_face, r_held_kind);
                    n_held_face = i_item.face;
                    n_held_kind = i_item.kind;
                end else if (i_item.last) begin
                    wr_en  = 1'b1;
                    wr_cmd = psms_pkg::make_single(i_item.face, i_item.kind);
                end else begin
                    n_held_valid = 1'b1;
                    n_held_face  = i_item.face;
                    n_held_kind  = i_item.kind;
                end
            end
        end

        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end

        o_result.step_lines = n_step;
        o_result.dir_lines  = n_dir;
        o_result.busy_res   = (n_phase != PH_IDLE) || (n_count != '0);
        o_result.accepted   = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= psms_pkg::HALF_PERIOD_RESET;
            r_settle      <= psms_pkg::SETTLE_RESET;
            r_dwell       <= psms_pkg::DWELL_RESET;
            r_quarter     <= psms_pkg::QUARTER_RESET;
            r_held_valid  <= 1'b0;
            r_held_face   <= '0;
            r_held_kind   <= '0;
            r_split       <= 1'b0;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
            r_phase       <= PH_IDLE;
            r_pulse       <= '0;
            r_time        <= '0;
            r_step        <= '0;
            r_dir         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psms_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_data[15:0];
                    psms_pkg::CFG_SETTLE:      r_settle      <= i_cfg_data[15:0];
                    psms_pkg::CFG_DWELL:       r_dwell       <= i_cfg_data;
                    psms_pkg::CFG_QUARTER:     r_quarter     <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            r_held_valid <= n_held_valid;
            r_held_face  <= n_held_face;
            r_held_kind  <= n_held_kind;
            r_split      <= n_split;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_count      <= n_count;
            r_phase      <= n_phase;
            r_pulse      <= n_pulse;
            r_time       <= n_time;
            r_step       <= n_step;
            r_dir        <= n_dir;
        end
    end

    // store write and registered head read, with bypass of a write to the head slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_ptr] <= wr_cmd;
        end
        if (wr_en && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= wr_cmd;
        end else begin
            r_head <= r_store[n_rd_ptr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_paired_stepper_move_sequencer.sv -----
// self-checking testbench for paired_stepper_move_sequencer: directed table, then random
// move sequences and tick runs checked against an in-bench motor sequencer model
// depends on psms_pkg and the paired_stepper_move_sequencer rtl
`default_nettype none

module tb_paired_stepper_move_sequencer;

    localparam int unsigned CODE_W = psms_pkg::CODE_W;
    localparam int unsigned FACE_W = psms_pkg::FACE_W;
    localparam int unsigned KIND_W = psms_pkg::KIND_W;
    localparam int unsigned LINE_W = psms_pkg::LINE_W;
    localparam int unsigned CFG_INDEX_W = psms_pkg::CFG_INDEX_W;
    localparam int unsigned CFG_DATA_W = psms_pkg::CFG_DATA_W;
    localparam int unsigned HALF_W = psms_pkg::HALF_W;
    localparam int unsigned SETTLE_W = psms_pkg::SETTLE_W;
    localparam int unsigned TIME_W = psms_pkg::TIME_W;
    localparam int unsigned QUARTER_W = psms_pkg::QUARTER_W;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned RESET_ROWS = 5;
    localparam int unsigned PROBE_ROWS = 26;

    typedef enum logic [2:0] {
        MP_IDLE, MP_SETTLE_A, MP_SETTLE_B, MP_JOINT, MP_EXTRA, MP_DWELL
    } t_motor_phase;

    typedef struct {
        logic               is_tick;
        logic [CODE_W-1:0]  code;
        logic               last;
        logic               typed;
        psms_pkg::t_result  want;
    } t_probe_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_mode;
    logic [CODE_W-1:0]       i_move_code;
    logic                    i_last_move;
    logic                    empty;
    logic                    pop;
    logic [LINE_W-1:0]       o_step_lines;
    logic [LINE_W-1:0]       o_dir_lines;
    logic                    o_busy_res;
    logic                    o_accepted;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    paired_stepper_move_sequencer #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_move_code  (i_move_code),
        .i_last_move  (i_last_move),
        .empty        (empty),
        .pop          (pop),
        .o_step_lines (o_step_lines),
        .o_dir_lines  (o_dir_lines),
        .o_busy_res   (o_busy_res),
        .o_accepted   (o_accepted),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // model of the sequencer: registers, pairing, command ring and motor back end
    logic [HALF_W-1:0]     cfg_half_period;
    logic [SETTLE_W-1:0]   cfg_settle;
    logic [TIME_W-1:0]     cfg_dwell;
    logic [QUARTER_W-1:0]  cfg_quarter;
    logic                  pend_valid;
    logic [CODE_W-1:0]     pend_code;
    psms_pkg::t_cmd        cmd_ring [DEPTH];
    int unsigned           ring_rd;
    int unsigned           ring_wr;
    int unsigned           ring_count;
    t_motor_phase          motor_phase;
    int unsigned           pulses_left;
    int unsigned           ticks_left;
    logic [LINE_W-1:0]     step_now;
    logic [LINE_W-1:0]     dir_now;

    psms_pkg::t_result pending_snapshots [$];
    int unsigned       mismatches;
    int unsigned       cycle_count;
    int unsigned       burst_left;
    logic              holdoff_req;
    t_probe_row        probe_rows [PROBE_ROWS];

    function automatic logic [FACE_W-1:0] across_from(input logic [FACE_W-1:0] face);
        case (face)
            3'd0:    return 3'd5;
            3'd1:    return 3'd3;
            3'd2:    return 3'd4;
            3'd3:    return 3'd1;
            3'd4:    return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [LINE_W-1:0] face_mask(input logic [FACE_W-1:0] face);
        return LINE_W'(1) << face;
    endfunction

    function automatic int unsigned quarter_len();
        return (cfg_quarter == '0) ? 1 : int'(cfg_quarter);
    endfunction

    function automatic int unsigned turn_steps(input logic [KIND_W-1:0] kind);
        return (kind == psms_pkg::KIND_HALF) ? 2 * quarter_len() : quarter_len();
    endfunction

    function automatic psms_pkg::t_cmd single_of(input logic [CODE_W-1:0] code);
        psms_pkg::t_cmd c;
        c = '0;
        c.face_a = FACE_W'(code / 3);
        c.kind_a = KIND_W'(code % 3);
        return c;
    endfunction

    function automatic void queue_command(input psms_pkg::t_cmd c);
        cmd_ring[ring_wr] = c;
        ring_wr = (ring_wr + 1) % DEPTH;
        ring_count++;
    endfunction

    function automatic void drive_dir(input logic [FACE_W-1:0] face,
                                      input logic [KIND_W-1:0] kind);
        dir_now[face] = (kind == psms_pkg::KIND_CW);
    endfunction

    function automatic void start_train(input t_motor_phase ph, input logic [LINE_W-1:0] mask,
                                        input int unsigned n);
        motor_phase = ph;
        step_now = mask;
        pulses_left = n;
        ticks_left = cfg_half_period;
    endfunction

    function automatic void start_wait(input t_motor_phase ph, input int unsigned len);
        motor_phase = ph;
        ticks_left = len;
    endfunction

    function automatic void start_joint(input psms_pkg::t_cmd c, input logic [LINE_W-1:0] mask);
        int unsigned n;
        n = turn_steps(c.kind_a);
        if (c.pair && turn_steps(c.kind_b) < n) begin
            n = turn_steps(c.kind_b);
        end
        start_train(MP_JOINT, mask, n);
    endfunction

    // one tick of a pulse train; high half, low half, then next pulse or done
    function automatic logic pulse_train_done(input logic [LINE_W-1:0] mask);
        if (ticks_left > 1) begin
            ticks_left--;
            return 1'b0;
        end
        ticks_left = cfg_half_period;
        if (step_now != '0) begin
            step_now = '0;
            return 1'b0;
        end
        if (pulses_left > 0) pulses_left--;
        if (pulses_left != 0) begin
            step_now = mask;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void motor_tick();
        psms_pkg::t_cmd    c;
        int unsigned       sa;
        int unsigned       sb;
        logic [LINE_W-1:0] mask;
        logic [LINE_W-1:0] longer;
        c = cmd_ring[ring_rd];
        sa = turn_steps(c.kind_a);
        sb = turn_steps(c.kind_b);
        mask = face_mask(c.face_a) | (c.pair ? face_mask(c.face_b) : '0);
        longer = (sa > sb) ? face_mask(c.face_a) : face_mask(c.face_b);
        case (motor_phase)
            MP_IDLE: begin
                if (ring_count != 0) begin
                    drive_dir(c.face_a, c.kind_a);
                    start_wait(MP_SETTLE_A, cfg_settle);
                end
            end
            MP_SETTLE_A: begin
                if (ticks_left > 1) begin
                    ticks_left--;
                end else if (c.pair) begin
                    drive_dir(c.face_b, c.kind_b);
                    start_wait(MP_SETTLE_B, cfg_settle);
                end else begin
                    start_joint(c, mask);
                end
            end
            MP_SETTLE_B: begin
                if (ticks_left > 1) ticks_left--;
                else start_joint(c, mask);
            end
            MP_JOINT: begin
                if (pulse_train_done(mask)) begin
                    if (c.pair && sa != sb) start_train(MP_EXTRA, longer, quarter_len());
                    else start_wait(MP_DWELL, cfg_dwell);
                end
            end
            MP_EXTRA: begin
                if (pulse_train_done(longer)) start_wait(MP_DWELL, cfg_dwell);
            end
            MP_DWELL: begin
                if (ticks_left > 1) begin
                    ticks_left--;
                end else begin
                    ring_rd = (ring_rd + 1) % DEPTH;
                    if (ring_count > 0) ring_count--;
                    motor_phase = MP_IDLE;
                end
            end
            default: motor_phase = MP_IDLE;
        endcase
    endfunction

    // pairing front end; returns 1 when the code is taken
    function automatic logic take_code(input logic [CODE_W-1:0] code, input logic last);
        psms_pkg::t_cmd joined;
        if (code > psms_pkg::CODE_MAX) return 1'b0;
        if (DEPTH - ring_count < 2) return 1'b0;
        if (pend_valid) begin
            if (across_from(FACE_W'(pend_code / 3)) == FACE_W'(code / 3)) begin
                joined = single_of(pend_code);
                joined.face_b = FACE_W'(code / 3);
                joined.kind_b = KIND_W'(code % 3);
                joined.pair = 1'b1;
                queue_command(joined);
                pend_valid = 1'b0;
                return 1'b1;
            end
            queue_command(single_of(pend_code));
        end
        if (last) begin
            queue_command(single_of(code));
            pend_valid = 1'b0;
        end else begin
            pend_code = code;
            pend_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic psms_pkg::t_result sequencer_lines(input logic is_tick,
                                                          input logic [CODE_W-1:0] code,
                                                          input logic last);
        psms_pkg::t_result r;
        r.accepted = 1'b0;
        if (is_tick) motor_tick();
        else r.accepted = take_code(code, last);
        r.step_lines = step_now;
        r.dir_lines = dir_now;
        r.busy_res = (motor_phase != MP_IDLE) || (ring_count != 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge after the beat is taken
    task automatic offer(input logic is_tick, input logic [CODE_W-1:0] code, input logic last,
                         input logic typed, input psms_pkg::t_result want);
        psms_pkg::t_result got;
        psms_pkg::t_result snap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_mode <= is_tick;
        i_move_code <= code;
        i_last_move <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        got = sequencer_lines(is_tick, code, last);
        snap = typed ? want : got;
        pending_snapshots = {pending_snapshots, snap};
        @(negedge i_clk);
    endtask

    // registers change only once every pending result is out
    task automatic load_setting(input logic [HALF_W-1:0] half, input logic [SETTLE_W-1:0] settle,
                                input logic [TIME_W-1:0] dwell,
                                input logic [QUARTER_W-1:0] quarter);
        logic [CFG_DATA_W-1:0] word [4];
        logic [CFG_INDEX_W-1:0] idx;
        push <= 1'b0;
        while (pending_snapshots.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        word[0] = {8'($urandom), half};
        word[1] = {8'($urandom), settle};
        word[2] = dwell;
        word[3] = {12'($urandom), quarter};
        for (int k = 0; k < 4; k++) begin
            idx = CFG_INDEX_W'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= word[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                psms_pkg::CFG_HALF_PERIOD: cfg_half_period = word[k][HALF_W-1:0];
                psms_pkg::CFG_SETTLE:      cfg_settle = word[k][SETTLE_W-1:0];
                psms_pkg::CFG_DWELL:       cfg_dwell = word[k][TIME_W-1:0];
                psms_pkg::CFG_QUARTER:     cfg_quarter = word[k][QUARTER_W-1:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int unsigned quota);
        int unsigned         sent;
        int unsigned         choice;
        int unsigned         len;
        logic [FACE_W-1:0]   face;
        logic [CODE_W-1:0]   code;
        sent = 0;
        while (sent < quota) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
                // well-formed sequence, often with opposite-face neighbours
                len = $urandom_range(1, 6);
                face = FACE_W'($urandom_range(0, 5));
                for (int k = 0; k < int'(len); k++) begin
                    if (k > 0 && $urandom_range(0, 1) == 1) face = across_from(face);
                    else face = FACE_W'($urandom_range(0, 5));
                    code = CODE_W'(face * 3 + $urandom_range(0, 2));
                    offer(1'b0, code, k == int'(len) - 1, 1'b0, '0);
                    sent++;
                    if ($urandom_range(0, 3) == 0) begin
                        offer(1'b1, 5'($urandom), 1'($urandom), 1'b0, '0);
                        sent++;
                    end
                end
            end else if (choice < 80) begin
                len = $urandom_range(1, 60);
                repeat (len) offer(1'b1, 5'($urandom), 1'($urandom), 1'b0, '0);
                sent += len;
            end else if (choice < 90) begin
                offer(1'b0, 5'($urandom), 1'($urandom), 1'b0, '0);
                sent++;
            end else if (choice < 95) begin
                // flood of moves with no time passing, runs the queue out of room
                repeat (18) offer(1'b0, CODE_W'($urandom_range(0, 17)), 1'b1, 1'b0, '0);
                sent += 18;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) offer(1'b0, CODE_W'($urandom_range(0, 17)), 1'b0, 1'b0, '0);
                sent += len;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n = 1'b0;
        push = 1'b0;
        i_mode = 1'b0;
        i_move_code = '0;
        i_last_move = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        holdoff_req = 1'b0;
        burst_left = 0;
        mismatches = 0;
        cfg_half_period = psms_pkg::HALF_PERIOD_RESET;
        cfg_settle = psms_pkg::SETTLE_RESET;
        cfg_dwell = psms_pkg::DWELL_RESET;
        cfg_quarter = psms_pkg::QUARTER_RESET;
        pend_valid = 1'b0;
        pend_code = '0;
        for (int k = 0; k < int'(DEPTH); k++) cmd_ring[k] = '0;
        ring_rd = 0;
        ring_wr = 0;
        ring_count = 0;
        motor_phase = MP_IDLE;
        pulses_left = 0;
        ticks_left = 0;
        step_now = '0;
        dir_now = '0;

        probe_rows = '{
            // reset state: tick, lone held code, bad code, opposite pair, first tick of it
            '{1'b1, 5'd0,  1'b0, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}},
            '{1'b0, 5'd17, 1'b0, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b1}},
            '{1'b0, 5'd31, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}},
            '{1'b0, 5'd0,  1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b1}},
            '{1'b1, 5'd0,  1'b0, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b0}},
            // left/right pair, non-opposite flush with last, lone last, bad code with last
            '{1'b0, 5'd3,  1'b0, 1'b0, '0},
            '{1'b0, 5'd10, 1'b0, 1'b0, '0},
            '{1'b0, 5'd6,  1'b0, 1'b0, '0},
            '{1'b0, 5'd1,  1'b1, 1'b0, '0},
            '{1'b0, 5'd12, 1'b1, 1'b0, '0},
            '{1'b0, 5'd20, 1'b1, 1'b0, '0},
            '{1'b0, 5'd14, 1'b0, 1'b0, '0},
            '{1'b0, 5'd8,  1'b0, 1'b0, '0},
            // fill the queue up to the last free pair of places
            '{1'b0, 5'd15, 1'b1, 1'b0, '0},
            '{1'b0, 5'd16, 1'b1, 1'b0, '0},
            '{1'b0, 5'd2,  1'b1, 1'b0, '0},
            '{1'b0, 5'd5,  1'b1, 1'b0, '0},
            '{1'b0, 5'd11, 1'b1, 1'b0, '0},
            '{1'b0, 5'd13, 1'b1, 1'b0, '0},
            '{1'b0, 5'd4,  1'b1, 1'b0, '0},
            '{1'b0, 5'd7,  1'b1, 1'b0, '0},
            '{1'b0, 5'd9,  1'b1, 1'b0, '0},
            '{1'b0, 5'd0,  1'b1, 1'b0, '0},
            '{1'b0, 5'd17, 1'b1, 1'b0, '0},
            '{1'b1, 5'd0,  1'b0, 1'b0, '0},
            '{1'b1, 5'd0,  1'b0, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < int'(PROBE_ROWS); r++) begin
            // low extremes, zero quarter count included
            if (r == int'(RESET_ROWS)) load_setting(16'd1, 16'd0, 24'd0, 12'd0);
            offer(probe_rows[r].is_tick, probe_rows[r].code, probe_rows[r].last,
                  probe_rows[r].typed, probe_rows[r].want);
        end
        random_traffic(300);

        load_setting(16'd2, 16'd1, 24'd3, 12'd1);
        holdoff_req = 1'b1;
        random_traffic(320);

        load_setting(16'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                     24'($urandom_range(0, 8)), 12'($urandom_range(1, 3)));
        random_traffic(320);

        load_setting(16'd3, 16'd4, 24'd6, 12'd3);
        holdoff_req = 1'b1;
        random_traffic(320);

        load_setting(16'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                     24'($urandom_range(0, 8)), 12'($urandom_range(1, 3)));
        random_traffic(320);

        // high extremes last: loaded counters never run out within the run
        load_setting(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 12'hFFF);
        random_traffic(100);

        push <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("paired_stepper_move_sequencer regression: pass");
        else $display("paired_stepper_move_sequencer regression: fail");
        $finish;
    end

    initial begin : result_side
        logic [7:0]  stall_pattern;
        int unsigned pattern_age;
        stall_pattern = 8'hFF;
        pattern_age = 0;
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            if (pattern_age == 0) begin
                pattern_age = 50;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            pattern_age--;
            pop <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
    end

    always @(posedge i_clk) begin : check_lines
        psms_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_snapshots.size() == 0) begin
                flag_mismatch($sformatf("beat with nothing pending: step %h dir %h busy %b acc %b",
                                        o_step_lines, o_dir_lines, o_busy_res, o_accepted));
            end else begin
                want = pending_snapshots.pop_front();
                if (o_step_lines !== want.step_lines)
                    flag_mismatch($sformatf("step_lines %h, want %h", o_step_lines,
                                            want.step_lines));
                if (o_dir_lines !== want.dir_lines)
                    flag_mismatch($sformatf("dir_lines %h, want %h", o_dir_lines, want.dir_lines));
                if (o_busy_res !== want.busy_res)
                    flag_mismatch($sformatf("busy_res %b, want %b", o_busy_res, want.busy_res));
                if (o_accepted !== want.accepted)
                    flag_mismatch($sformatf("accepted %b, want %b", o_accepted, want.accepted));
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("paired_stepper_move_sequencer regression: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/psms_pkg.sv
design/psms_fifo.sv
design/psms_front.sv
design/psms_back.sv
design/paired_stepper_move_sequencer.sv
tb/sv/tb_paired_stepper_move_sequencer.sv
